FILE: hdl/squared_tv_gradient_stencil_macros.svh
// Assertion macros for the squared TV gradient stencil.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef SQUARED_TV_GRADIENT_STENCIL_MACROS_SVH
`define SQUARED_TV_GRADIENT_STENCIL_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SQTV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define SQTV_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hdl/sqtv_pkg.sv
// Shared types and constants for the squared TV gradient stencil.
// No dependencies.
package sqtv_pkg;

  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 16;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_IDX_BITS    = 1;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd256;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd256;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_e;

  // Neighbour selection and frame marker carried with an item in flight
  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
    logic last;
  } nbr_ctrl_t;

endpackage

FILE: hdl/squared_tv_gradient_stencil.sv
// Squared TV gradient, 4-neighbour Laplacian stencil over a raster pixel stream.
// Depends on sqtv_pkg and squared_tv_gradient_stencil_macros.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   in      | sink      | in_valid_i / in_stall_o | action_i, pixel_value_i
//   out     | source    | out_valid_o / out_stall_i | gradient_value_o, last_of_frame_o
//   cfg     | sink      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item per cycle unless in_stall_o is high; a result passes through the compute
// stage, fed by the registered two-row line buffer read, and then the result register.
// Reset clears counters and valid flags; the line buffer is not cleared.
// in_stall_o rises only while both the compute stage and result register are full.
`include "squared_tv_gradient_stencil_macros.svh"

module squared_tv_gradient_stencil
  import sqtv_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic signed [PIXEL_BITS-1:0]   pixel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [PIXEL_BITS+3:0]   gradient_value_o,
  output logic                           last_of_frame_o,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]       cfg_data_i
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int WB       = CW + 1;
  localparam int AW       = CW + 1;
  localparam int MemDepth = 2 ** AW;
  localparam int OB       = PIXEL_BITS + 4;
  localparam int WCMP     = (WB > WIDTH_REG_BITS) ? WB : WIDTH_REG_BITS;
  localparam int HB       = HEIGHT_REG_BITS;

  logic [WIDTH_REG_BITS-1:0] width_q;
  logic [HB-1:0]             height_q;
  logic [WB-1:0]             w_eff;
  logic [HB-1:0]             h_eff;
  logic [WCMP-1:0]           width_ext;

  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HB-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  logic signed [PIXEL_BITS-1:0] cen_q, cen_d, lft_q, lft_d, cur_c;
  logic                         cen_mem_q, cen_mem_d;

  logic signed [PIXEL_BITS-1:0] mem [MemDepth];
  logic signed [PIXEL_BITS-1:0] rd_right_q, rd_up_q;
  logic [AW-1:0]                waddr, raddr_right, raddr_up;
  logic                         mem_we;

  logic                         v1_q, vo_q;
  logic signed [PIXEL_BITS-1:0] c1_q, l1_q, d1_q;
  nbr_ctrl_t                    s1_q, s1_d;
  logic signed [OB-1:0]         grad_q;
  logic                         last_q;

  logic acc, emit, out_ready, in_ready, in_col_end, out_col_end;
  logic signed [OB-1:0] dl, dr, du, dd, sum, grad_d;

  // Effective frame size
  always_comb begin
    width_ext = WCMP'(width_q);
    if (width_q == '0) begin
      w_eff = WB'(1);
    end else if (width_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(width_ext);
    end
    h_eff = (height_q == '0) ? HB'(1) : height_q;
  end

  assign out_ready  = !vo_q || !out_stall_i;
  assign in_ready   = !v1_q || out_ready;
  assign in_stall_o = !in_ready;
  assign acc        = in_valid_i && in_ready;

  assign cur_c       = cen_mem_q ? rd_right_q : cen_q;
  assign in_col_end  = ({1'b0, in_col_q} + WB'(1)) >= w_eff;
  assign out_col_end = ({1'b0, out_col_q} + WB'(1)) >= w_eff;

  assign waddr       = {in_row_q[0], in_col_q};
  assign raddr_up    = {~out_row_q[0], out_col_q};
  assign raddr_right = out_col_end ? {~out_row_q[0], CW'(0)}
                                   : {out_row_q[0], out_col_q + CW'(1)};

  // Step control: position counters, centre/left window and neighbour flags
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    cen_d     = cen_q;
    cen_mem_d = cen_mem_q;
    lft_d     = lft_q;
    mem_we    = 1'b0;
    emit      = 1'b0;
    s1_d      = '0;
    if (cfg_we_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (acc) begin
      if (action_i == ACT_PIXEL) begin
        if (in_row_q < h_eff) begin
          mem_we = 1'b1;
          emit   = (in_row_q != '0);
          if (in_row_q == '0 && in_col_q == '0) begin
            cen_d     = pixel_value_i;
            cen_mem_d = 1'b0;
          end
          if (in_col_end) begin
            in_col_d = '0;
            in_row_d = in_row_q + HB'(1);
          end else begin
            in_col_d = in_col_q + CW'(1);
          end
        end
      end else begin
        emit = (in_row_q >= h_eff)
            && (({1'b0, out_row_q} + (HB+1)'(1)) == {1'b0, h_eff});
        s1_d.last = out_col_end;
      end
      if (emit) begin
        s1_d.left  = (out_col_q != '0);
        s1_d.right = !out_col_end;
        s1_d.up    = (out_row_q != '0);
        s1_d.down  = (action_i == ACT_PIXEL);
        lft_d      = cur_c;
        if (out_col_end && w_eff == WB'(1) && action_i == ACT_PIXEL) begin
          cen_d     = pixel_value_i;
          cen_mem_d = 1'b0;
        end else begin
          cen_mem_d = 1'b1;
        end
        if (out_col_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + HB'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
        if (s1_d.last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
      end
    end
  end

  // Line buffer: row parity and column address, old data on a colliding read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= pixel_value_i;
    end
    if (emit) begin
      rd_right_q <= mem[raddr_right];
      rd_up_q    <= mem[raddr_up];
    end
  end

  // Stencil sum for the item in the compute stage
  always_comb begin
    dl = s1_q.left  ? (OB'(c1_q) - OB'(l1_q))       : '0;
    dr = s1_q.right ? (OB'(c1_q) - OB'(rd_right_q)) : '0;
    du = s1_q.up    ? (OB'(c1_q) - OB'(rd_up_q))    : '0;
    dd = s1_q.down  ? (OB'(c1_q) - OB'(d1_q))       : '0;
    sum    = dl + dr + du + dd;
    grad_d = sum <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      cen_mem_q <= 1'b0;
      v1_q      <= 1'b0;
      vo_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_BITS-1:0];
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HB-1:0];
          default: ;
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      cen_mem_q <= cen_mem_d;
      if (in_ready) begin
        v1_q <= emit;
      end
      if (out_ready) begin
        vo_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cen_q <= cen_d;
    lft_q <= lft_d;
    if (emit) begin
      c1_q <= cur_c;
      l1_q <= lft_q;
      d1_q <= pixel_value_i;
      s1_q <= s1_d;
    end
    if (out_ready && v1_q) begin
      grad_q <= grad_d;
      last_q <= s1_q.last;
    end
  end

  assign out_valid_o      = vo_q;
  assign gradient_value_o = grad_q;
  assign last_of_frame_o  = last_q;

  `SQTV_ASSERT(a_s1_hold, v1_q && !out_ready |=> v1_q && $stable(c1_q) && $stable(s1_q), "compute stage lost its item while blocked")
  `SQTV_ASSERT_NEVER(a_col_range, ({1'b0, in_col_q} >= w_eff) || ({1'b0, out_col_q} >= w_eff), "column counter beyond image width")
  `SQTV_ASSERT(a_last_restart, emit && s1_d.last |=> in_row_q == '0 && out_row_q == '0 && out_col_q == '0, "frame did not restart after its last item")

endmodule
